// File: hw/rtl/rdc_pkg.sv
// Shared constants and types of the radix digit converter.
`default_nettype none
package rdc_pkg;
   localparam int MAX_DIGITS_DEF = 32;
   localparam int VALUE_BITS_DEF = 31;
   localparam int RADIX_BITS     = 5;
   localparam int DIGIT_BITS     = 4;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_POP,
      ST_OUT
   } rdc_state_type;
endpackage
`default_nettype wire

// File: hw/rtl/rdc_if.sv
// Valid/ready channel interfaces for the converter's request and response sides.
`default_nettype none
interface rdc_req_if #(
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface rdc_rsp_if ();
   import rdc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [DIGIT_BITS-1:0] digit;
   logic                  last;

   modport source (output valid, output digit, output last, input ready);
   modport sink (input valid, input digit, input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rdc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/rdc_div.sv
// Bit-serial restoring divider: value by radix, one quotient bit per cycle.
`default_nettype none
module rdc_div #(
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [VALUE_BITS-1:0]             dividend,
   input  wire logic [rdc_pkg::RADIX_BITS-1:0]    divisor,
   output      logic                              done,
   output      logic [VALUE_BITS-1:0]             quotient,
   output      logic [rdc_pkg::DIGIT_BITS-1:0]    remainder
);
   import rdc_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] q_ff, q_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [RADIX_BITS-1:0] divisor_ff, divisor_in;
   logic [RADIX_BITS-1:0] trial;
   logic [RADIX_BITS-1:0] diff;
   logic                  qbit;

   // Partial remainder stays below the divisor, so four bits plus the next
   // dividend bit always fit the radix width.
   assign trial = {rem_ff, q_ff[VALUE_BITS-1]};
   assign qbit  = (trial >= divisor_ff);
   assign diff  = trial - divisor_ff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      q_in       = q_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_BITS'(VALUE_BITS);
         q_in       = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         q_in   = {q_ff[VALUE_BITS-2:0], qbit};
         rem_in = qbit ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, rem_ff} < divisor_ff))
      else $error("remainder not below divisor");
   a_busy_counts: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("bit counter did not advance");
endmodule
`default_nettype wire

// File: hw/rtl/radix_digit_converter_core.sv
// Top level of the radix digit converter: sequencer, digit stack and divider.
`default_nettype none
// Converts a non-negative integer to its digits in the base held in the radix
// register (2 to 16; any other setting, and a value of zero, produce no digits)
// and returns them most significant first, one response item per digit, with
// last set on the least significant digit. Up to MAX_DIGITS low digits are
// kept; more significant ones are dropped. The block takes one request item at
// a time and is not ready again until the final digit has been taken. Each
// digit comes from the shared bit-serial divider (one quotient bit per cycle)
// and is pushed onto the digit stack RAM; the digits are then read back from
// the stack and each is held on the response until it has been taken. Write
// the radix only while the block is idle.
module radix_digit_converter_core #(
   parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF,
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rdc_req_if.sink                             req_chan,
   rdc_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_wr_en,
   input  wire logic [rdc_pkg::RADIX_BITS-1:0] csr_wr_data
);
   import rdc_pkg::*;

   localparam int ADDR_BITS = $clog2(MAX_DIGITS);
   localparam int CNT_BITS  = $clog2(MAX_DIGITS + 1);

   rdc_state_type         state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [RADIX_BITS-1:0] radix_ff;

   logic                  req_fire, rsp_fire;
   logic                  radix_ok, go, more;
   logic                  div_start, div_done;
   logic [VALUE_BITS-1:0] div_dividend, div_quotient;
   logic [DIGIT_BITS-1:0] div_remainder;
   logic                  ram_wr_en, ram_rd_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr, ram_rd_addr;
   logic [DIGIT_BITS-1:0] ram_rd_data;
   logic [CNT_BITS-1:0]   count_dec;

   assign req_fire  = req_chan.valid & req_chan.ready;
   assign rsp_fire  = rsp_chan.valid & rsp_chan.ready;
   assign radix_ok  = (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX);
   assign go        = radix_ok && (req_chan.value != '0);
   // Keep dividing while the quotient is nonzero and the stack has room.
   assign more      = (div_quotient != '0) && (count_ff < CNT_BITS'(MAX_DIGITS - 1));
   assign count_dec = count_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_wr_en) begin
         radix_ff <= csr_wr_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && go) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done && !more) state_in = ST_POP;
         end
         ST_POP: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_fire) state_in = (count_ff == '0) ? ST_IDLE : ST_POP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      div_start      = 1'b0;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      count_in       = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            div_start      = req_chan.valid && go;
            count_in       = '0;
         end
         ST_DIV: begin
            if (div_done) begin
               ram_wr_en = 1'b1;
               div_start = more;
               count_in  = count_ff + 1'b1;
            end
         end
         ST_POP: begin
            ram_rd_en = 1'b1;
            count_in  = count_dec;
         end
         ST_OUT: begin
            rsp_chan.valid = 1'b1;
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign div_dividend = (state_ff == ST_IDLE) ? req_chan.value : div_quotient;
   assign ram_wr_addr  = count_ff[ADDR_BITS-1:0];
   assign ram_rd_addr  = count_dec[ADDR_BITS-1:0];

   rdc_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (radix_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   rdc_ram #(
      .WIDTH (DIGIT_BITS),
      .DEPTH (MAX_DIGITS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (div_remainder),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_chan.digit = ram_rd_data;
   assign rsp_chan.last  = (count_ff == '0);

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide phase");
   a_push_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (count_ff < CNT_BITS'(MAX_DIGITS)))
      else $error("digit push past stack depth");
   a_no_work_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !go) |=> (state_ff == ST_IDLE))
      else $error("item without digits left idle");
   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_chan.last) |=> (state_ff == ST_IDLE && count_ff == '0))
      else $error("final digit did not end the item");
endmodule
`default_nettype wire
